>>> sv/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg: shared types and constants of the stack bytecode executor
// Opcodes, error codes, default sizes and the request/response structs that
// pass between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned RegCountDef   = 16;
  localparam int unsigned CallDepthDef  = 64;
  localparam int unsigned IpWidthDef    = 16;

  localparam int unsigned DataW   = 64;
  localparam int unsigned ActionW = 6;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned CurIpW  = 16;
  localparam int unsigned DepthW  = 9;
  localparam int unsigned ErrW    = 3;

  // opcodes
  localparam logic [ActionW-1:0] OpNop   = 6'd0;
  localparam logic [ActionW-1:0] OpHalt  = 6'd1;
  localparam logic [ActionW-1:0] OpPush  = 6'd2;
  localparam logic [ActionW-1:0] OpPop   = 6'd3;
  localparam logic [ActionW-1:0] OpDup   = 6'd4;
  localparam logic [ActionW-1:0] OpJmp   = 6'd5;
  localparam logic [ActionW-1:0] OpJmpIf = 6'd6;
  localparam logic [ActionW-1:0] OpEq    = 6'd7;
  localparam logic [ActionW-1:0] OpNeq   = 6'd8;
  localparam logic [ActionW-1:0] OpLt    = 6'd9;
  localparam logic [ActionW-1:0] OpGt    = 6'd10;
  localparam logic [ActionW-1:0] OpLe    = 6'd11;
  localparam logic [ActionW-1:0] OpGe    = 6'd12;
  localparam logic [ActionW-1:0] OpMov   = 6'd13;
  localparam logic [ActionW-1:0] OpLoad  = 6'd14;
  localparam logic [ActionW-1:0] OpAdd   = 6'd15;
  localparam logic [ActionW-1:0] OpSub   = 6'd16;
  localparam logic [ActionW-1:0] OpMul   = 6'd17;
  localparam logic [ActionW-1:0] OpDiv   = 6'd18;
  localparam logic [ActionW-1:0] OpInc   = 6'd19;
  localparam logic [ActionW-1:0] OpMod   = 6'd20;
  localparam logic [ActionW-1:0] OpPow   = 6'd21;
  localparam logic [ActionW-1:0] OpAbs   = 6'd22;
  localparam logic [ActionW-1:0] OpMin   = 6'd23;
  localparam logic [ActionW-1:0] OpMax   = 6'd24;
  localparam logic [ActionW-1:0] OpAnd   = 6'd25;
  localparam logic [ActionW-1:0] OpOr    = 6'd26;
  localparam logic [ActionW-1:0] OpXor   = 6'd27;
  localparam logic [ActionW-1:0] OpNot   = 6'd28;
  localparam logic [ActionW-1:0] OpShl   = 6'd29;
  localparam logic [ActionW-1:0] OpShr   = 6'd30;
  localparam logic [ActionW-1:0] OpCall  = 6'd31;
  localparam logic [ActionW-1:0] OpRet   = 6'd32;

  // error codes
  localparam logic [ErrW-1:0] ErrNone    = 3'd0;
  localparam logic [ErrW-1:0] ErrDivZero = 3'd1;
  localparam logic [ErrW-1:0] ErrModZero = 3'd2;
  localparam logic [ErrW-1:0] ErrUnder   = 3'd3;
  localparam logic [ErrW-1:0] ErrOver    = 3'd4;
  localparam logic [ErrW-1:0] ErrCallOvf = 3'd5;

  // request to the shared unit
  typedef struct packed {
    logic                   start;
    logic [ActionW-1:0]     action;
    logic [DataW-1:0]       a;
    logic [DataW-1:0]       b;
  } alu_req_t;

  // response from the shared unit
  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

>>> sv/sbe_alu.sv
// ----------------------------------------------------------------------------
// sbe_alu: shared arithmetic unit
// Registered logic, add, compare and shift operations; a 64-bit multiply
// built from 32x32 partial products; a radix-2 divider for quotient and
// remainder; power by repeated squaring on the same multiplier.
// ----------------------------------------------------------------------------
module sbe_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbe_pkg::alu_req_t req_i,
  output sbe_pkg::alu_rsp_t rsp_o
);
  import sbe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_DIVFIN, S_POW_CHK, S_POW_RM, S_POW_BM, S_DONE
  } state_e;

  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned CntW  = $clog2(DataW + 1);

  state_e               state_q;
  logic [ActionW-1:0]   op_q;
  logic [DataW-1:0]     a_q, b_q, res_q;
  // multiplier operands and partial product step
  logic [DataW-1:0]     mx_q, my_q, macc_q;
  logic [1:0]           mstep_q;
  logic                 mpow_r_q;   // power: 1 result multiply, 0 base square
  // divider
  logic [DataW-1:0]     dq_q, dr_q, dd_q;
  logic [CntW-1:0]      cnt_q;
  // power
  logic [DataW-1:0]     pr_q, pb_q, pe_q;

  logic [DataW-1:0]     mag_a, mag_b, sub_res;
  logic [HalfW-1:0]     pp_x, pp_y;
  logic [DataW-1:0]     pp;
  logic [DataW:0]       rtrial;
  logic                 slt_ab, slt_ba;

  assign mag_a  = a_q[DataW-1] ? (~a_q + DataW'(1)) : a_q;
  assign mag_b  = b_q[DataW-1] ? (~b_q + DataW'(1)) : b_q;
  assign slt_ab = $signed(req_i.a) < $signed(req_i.b);
  assign slt_ba = $signed(req_i.b) < $signed(req_i.a);

  // one 32x32 partial product per step: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (mstep_q)
      2'd0:    begin pp_x = mx_q[HalfW-1:0];     pp_y = my_q[HalfW-1:0];     end
      2'd1:    begin pp_x = mx_q[HalfW-1:0];     pp_y = my_q[DataW-1:HalfW]; end
      default: begin pp_x = mx_q[DataW-1:HalfW]; pp_y = my_q[HalfW-1:0];     end
    endcase
  end
  assign pp = DataW'(pp_x) * DataW'(pp_y);

  // divider trial subtract
  assign rtrial  = {dr_q, dq_q[DataW-1]} - {1'b0, dd_q};
  assign sub_res = dr_q;

  // combinational result of the simple operations
  logic [DataW-1:0] quick;
  always_comb begin
    case (req_i.action)
      OpEq:    quick = DataW'(req_i.a == req_i.b);
      OpNeq:   quick = DataW'(req_i.a != req_i.b);
      OpLt:    quick = DataW'(slt_ab);
      OpGt:    quick = DataW'(slt_ba);
      OpLe:    quick = DataW'(!slt_ba);
      OpGe:    quick = DataW'(!slt_ab);
      OpAdd:   quick = req_i.a + req_i.b;
      OpSub:   quick = req_i.a - req_i.b;
      OpInc:   quick = req_i.a + DataW'(1);
      OpAbs:   quick = req_i.a[DataW-1] ? (~req_i.a + DataW'(1)) : req_i.a;
      OpMin:   quick = slt_ba ? req_i.b : req_i.a;
      OpMax:   quick = slt_ab ? req_i.b : req_i.a;
      OpAnd:   quick = req_i.a & req_i.b;
      OpOr:    quick = req_i.a | req_i.b;
      OpXor:   quick = req_i.a ^ req_i.b;
      OpNot:   quick = ~req_i.a;
      OpShl:   quick = req_i.a << req_i.b[5:0];
      OpShr:   quick = DataW'($signed(req_i.a) >>> req_i.b[5:0]);
      default: quick = '0;
    endcase
  end

  // sequencer of the unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            op_q <= req_i.action;
            a_q  <= req_i.a;
            b_q  <= req_i.b;
            case (req_i.action)
              OpMul: begin
                mx_q <= req_i.a; my_q <= req_i.b; macc_q <= '0; mstep_q <= 2'd0;
                mpow_r_q <= 1'b0;
                state_q <= S_MUL;
              end
              OpDiv, OpMod: begin
                cnt_q   <= '0;
                state_q <= S_DIV;
              end
              OpPow: begin
                pr_q <= DataW'(1); pb_q <= req_i.a; pe_q <= req_i.b;
                mstep_q <= 2'd0;
                state_q <= S_POW_CHK;
              end
              default: begin
                res_q   <= quick;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          if (mstep_q == 2'd0) begin
            macc_q <= macc_q + pp;
          end else begin
            macc_q <= macc_q + {pp[HalfW-1:0], {HalfW{1'b0}}};
          end
          if (mstep_q == 2'd2) begin
            mstep_q <= 2'd0;
            if (op_q == OpMul) begin
              res_q   <= macc_q + {pp[HalfW-1:0], {HalfW{1'b0}}};
              state_q <= S_DONE;
            end else begin
              state_q <= mpow_r_q ? S_POW_RM : S_POW_BM;
            end
          end else begin
            mstep_q <= mstep_q + 2'd1;
          end
        end
        S_DIV: begin
          // first cycle loads magnitudes, then one bit per cycle
          if (cnt_q == '0) begin
            dq_q  <= mag_a;
            dr_q  <= '0;
            dd_q  <= mag_b;
            cnt_q <= CntW'(1);
          end else begin
            if (!rtrial[DataW]) begin
              dr_q <= rtrial[DataW-1:0];
              dq_q <= {dq_q[DataW-2:0], 1'b1};
            end else begin
              dr_q <= {dr_q[DataW-2:0], dq_q[DataW-1]};
              dq_q <= {dq_q[DataW-2:0], 1'b0};
            end
            if (cnt_q == CntW'(DataW)) state_q <= S_DIVFIN;
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_DIVFIN: begin
          if (op_q == OpDiv) begin
            res_q <= (a_q[DataW-1] ^ b_q[DataW-1]) ? (~dq_q + DataW'(1)) : dq_q;
          end else begin
            res_q <= a_q[DataW-1] ? (~sub_res + DataW'(1)) : sub_res;
          end
          state_q <= S_DONE;
        end
        S_POW_CHK: begin
          if (pe_q[DataW-1] || pe_q == '0) begin
            res_q   <= pr_q;
            state_q <= S_DONE;
          end else if (pe_q[0]) begin
            mx_q <= pr_q; my_q <= pb_q; macc_q <= '0; mpow_r_q <= 1'b1;
            state_q <= S_MUL;
          end else begin
            mx_q <= pb_q; my_q <= pb_q; macc_q <= '0; mpow_r_q <= 1'b0;
            state_q <= S_MUL;
          end
        end
        S_POW_RM: begin
          // result updated, now square the base
          pr_q <= macc_q;
          mx_q <= pb_q; my_q <= pb_q; macc_q <= '0; mpow_r_q <= 1'b0;
          state_q <= S_MUL;
        end
        S_POW_BM: begin
          pb_q    <= macc_q;
          pe_q    <= pe_q >> 1;
          state_q <= S_POW_CHK;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.result = res_q;

endmodule

>>> sv/stack_bytecode_executor.sv
// ----------------------------------------------------------------------------
// stack_bytecode_executor: one stack machine instruction per transaction
// Sequencer with data stack, register file and return stack, using a shared
// arithmetic unit for everything that computes a value.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one instruction per transaction, m_axis one result.
//   The block takes an instruction only when idle; s_axis_tready is low from
//   acceptance until its result has been taken on m_axis.
//   Stack, jump, compare and logic operations take two stack memory reads, a
//   pass through the shared unit and a writeback; an instruction that ends
//   in an error skips the unit and the writeback and goes straight to its
//   result. Multiply runs on the 32x32 partial product multiplier; divide
//   and modulo run on the one-bit-per-cycle divider; power runs a base
//   square, and a result multiply for each set bit, for each exponent bit
//   up to its highest one.
//   Reset empties the data and return stacks and clears the register file
//   at once; no clearing pass is needed.
//   A stalled m_axis holds the result and the block stays busy until it is
//   taken.
// ----------------------------------------------------------------------------
module stack_bytecode_executor #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::StackDepthDef,
  parameter int unsigned REG_COUNT   = sbe_pkg::RegCountDef,
  parameter int unsigned CALL_DEPTH  = sbe_pkg::CallDepthDef,
  parameter int unsigned IP_WIDTH    = sbe_pkg::IpWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[5:0], operand[69:6], reg_index[73:70], current_ip[89:74], zero fill
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_ip[15:0], keep_running[16], top_value[80:17], stack_depth[89:81],
  // error_code[92:90], zero fill
  output logic [95:0]  m_axis_tdata
);
  import sbe_pkg::*;

  localparam int unsigned SpW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW  = $clog2(STACK_DEPTH);
  localparam int unsigned RpW  = $clog2(CALL_DEPTH + 1);
  localparam int unsigned RaW  = $clog2(CALL_DEPTH);
  localparam int unsigned RiW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_B, S_RD_A, S_EXEC, S_WAIT, S_WB, S_OUT
  } state_e;

  state_e               state_q;
  logic [ActionW-1:0]   act_q;
  logic [DataW-1:0]     opnd_q;
  logic [RegIdxW-1:0]   ridx_q;
  logic [IP_WIDTH-1:0]  cur_q, next_q;
  logic [SpW-1:0]       sp_q;
  logic [RpW-1:0]       rp_q;
  logic [DataW-1:0]     a_q, b_q, res_q, top_q;
  logic [1:0]           pops_q, pushes_q;
  logic                 run_q;
  logic [ErrW-1:0]      err_q;
  logic [DataW-1:0]     out_top_q;
  logic [SpW-1:0]       out_sp_q;

  logic [DataW-1:0]     dstk [STACK_DEPTH];
  logic [IP_WIDTH-1:0]  rstk [CALL_DEPTH];
  logic [DataW-1:0]     regs_q [REG_COUNT];

  logic [DataW-1:0]     drd_q;
  logic [IP_WIDTH-1:0]  rrd_q;
  logic [SaW-1:0]       drd_addr;
  logic                 dwr_en;
  logic [SaW-1:0]       dwr_addr;
  logic [DataW-1:0]     dwr_data;

  alu_req_t             req;
  alu_rsp_t             rsp;

  // decode of the accepted instruction
  logic [ActionW-1:0]   in_act;
  logic [RegIdxW-1:0]   in_ridx;
  logic                 in_reg_ok;
  logic [1:0]           in_pops, in_pushes;
  assign in_act    = s_axis_tdata[5:0];
  assign in_ridx   = s_axis_tdata[73:70];
  assign in_reg_ok = 32'(in_ridx) < REG_COUNT;

  always_comb begin
    in_pops = 2'd0; in_pushes = 2'd0;
    case (in_act)
      OpPush:               in_pushes = 2'd1;
      OpLoad:               in_pushes = {1'b0, in_reg_ok};
      OpPop, OpJmpIf:       in_pops = 2'd1;
      OpMov:                in_pops = {1'b0, in_reg_ok};
      OpDup:                begin in_pops = 2'd1; in_pushes = 2'd2; end
      OpInc, OpAbs, OpNot:  begin in_pops = 2'd1; in_pushes = 2'd1; end
      default: begin
        if ((in_act >= OpEq && in_act <= OpGe) || (in_act >= OpAdd && in_act <= OpShr)) begin
          in_pops = 2'd2; in_pushes = 2'd1;
        end
      end
    endcase
  end

  // stack memory read address: top first, then second
  always_comb begin
    if (state_q == S_RD_B) drd_addr = SaW'(sp_q - SpW'(1));
    else                   drd_addr = SaW'(sp_q - SpW'(2));
  end

  // data stack memory
  always_ff @(posedge clk_i) begin
    if (dwr_en) dstk[dwr_addr] <= dwr_data;
    drd_q <= dstk[drd_addr];
  end

  // return stack memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && err_q == ErrNone && act_q == OpCall) begin
      rstk[RaW'(rp_q)] <= cur_q + IP_WIDTH'(1);
    end
    rrd_q <= rstk[RaW'(rp_q - RpW'(1))];
  end

  // writeback port: a single push and the first of two go out in S_WB, the second of two in S_OUT
  always_comb begin
    dwr_en   = 1'b0;
    dwr_addr = SaW'(sp_q);
    dwr_data = res_q;
    if (state_q == S_WB && err_q == ErrNone) begin
      if (pushes_q == 2'd2) begin
        dwr_en = 1'b1; dwr_addr = SaW'(sp_q - SpW'(1)); dwr_data = a_q;
      end else if (pushes_q == 2'd1) begin
        dwr_en = 1'b1; dwr_addr = SaW'(sp_q - SpW'(pops_q)); dwr_data = res_q;
      end
    end else if (state_q == S_OUT && pushes_q == 2'd2 && err_q == ErrNone && !m_axis_tvalid) begin
      dwr_en = 1'b1; dwr_addr = SaW'(sp_q - SpW'(1)); dwr_data = res_q;
    end
  end

  // binary operations: the second entry arrives from memory in S_EXEC
  assign req.start  = (state_q == S_EXEC) && (err_q == ErrNone);
  assign req.action = (act_q == OpDup || act_q == OpPush || act_q == OpLoad) ? OpNop : act_q;
  assign req.a      = (pops_q == 2'd2) ? drd_q : a_q;
  assign req.b      = b_q;

  sbe_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      sp_q          <= '0;
      rp_q          <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act_q    <= in_act;
            opnd_q   <= s_axis_tdata[69:6];
            ridx_q   <= in_ridx;
            cur_q    <= IP_WIDTH'(s_axis_tdata[89:74]);
            next_q   <= IP_WIDTH'(s_axis_tdata[89:74]) + IP_WIDTH'(1);
            pops_q   <= in_pops;
            pushes_q <= in_pushes;
            run_q    <= 1'b1;
            if (32'(sp_q) < 32'(in_pops)) begin
              err_q <= ErrUnder;
            end else if (32'(sp_q) - 32'(in_pops) + 32'(in_pushes) > STACK_DEPTH) begin
              err_q <= ErrOver;
            end else if (in_act == OpCall && 32'(rp_q) >= CALL_DEPTH) begin
              err_q <= ErrCallOvf;
            end else begin
              err_q <= ErrNone;
            end
            state_q <= S_RD_B;
          end
        end
        S_RD_B: state_q <= S_RD_A;  // top read in flight
        S_RD_A: begin
          top_q <= drd_q;
          if (pops_q == 2'd2) begin
            b_q <= drd_q;
            if (err_q == ErrNone && drd_q == '0 && act_q == OpDiv) err_q <= ErrDivZero;
            if (err_q == ErrNone && drd_q == '0 && act_q == OpMod) err_q <= ErrModZero;
          end else begin
            a_q <= drd_q;
            b_q <= '0;
          end
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (pops_q == 2'd2) a_q <= drd_q;
          if (pops_q == 2'd0) a_q <= '0;
          if (err_q != ErrNone) begin
            run_q   <= 1'b0;
            next_q  <= cur_q;
            state_q <= S_OUT;
          end else begin
            // pop only: the second entry becomes the new top
            if (pops_q == 2'd1 && pushes_q == 2'd0) top_q <= drd_q;
            case (act_q)
              OpHalt: run_q <= 1'b0;
              OpJmp:  next_q <= IP_WIDTH'(opnd_q);
              OpJmpIf: if (drd_q != '0 || top_q != '0) begin
                // condition is the top, held in top_q
                if (top_q != '0) next_q <= IP_WIDTH'(opnd_q);
              end
              OpMov: if (32'(ridx_q) < REG_COUNT) regs_q[RiW'(ridx_q)] <= top_q;
              OpCall: begin
                rp_q   <= rp_q + RpW'(1);
                next_q <= IP_WIDTH'(opnd_q);
              end
              OpRet: begin
                if (rp_q == '0) run_q <= 1'b0;
                else begin
                  rp_q   <= rp_q - RpW'(1);
                  next_q <= rrd_q;
                end
              end
              default: ;
            endcase
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            case (act_q)
              OpPush: res_q <= opnd_q;
              OpDup:  res_q <= a_q;
              OpLoad: res_q <= (32'(ridx_q) < REG_COUNT) ? regs_q[RiW'(ridx_q)] : '0;
              default: res_q <= rsp.result;
            endcase
            state_q <= S_WB;
          end
        end
        S_WB: begin
          sp_q <= sp_q - SpW'(pops_q) + SpW'(pushes_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            out_sp_q      <= sp_q;
            if (err_q == ErrNone && pushes_q != 2'd0) out_top_q <= res_q;
            else if (sp_q == '0) out_top_q <= '0;
            else out_top_q <= top_q;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tdata  = {3'b000, err_q, DepthW'(out_sp_q), out_top_q, run_q,
                          CurIpW'(next_q)};

endmodule

>>> sv/sbe_checker.sv
// ----------------------------------------------------------------------------
// sbe_checker: port-level checks of the stack bytecode executor
// Watches the stream ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module sbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);
  import sbe_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // busy while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");

  // an error always stops the run
  a_err_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[92:90] != ErrNone |-> !m_axis_tdata[16])
    else $error("error without halt");

  // accepted instruction leaves the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

endmodule

bind stack_bytecode_executor sbe_checker u_sbe_checker (.*);

>>> verif/stack_bytecode_executor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_executor_checker: result predictor and comparator
// Watches the instruction and result streams, runs its own copy of the stack
// machine for every accepted instruction and compares each result field.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_checker
  import sbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          sp_o,
  output int          rp_o
);

  localparam int StackMax = StackDepthDef;
  localparam int CallMax  = CallDepthDef;

  typedef struct packed {
    logic [ErrW-1:0]   err;
    logic [DepthW-1:0] depth;
    logic [DataW-1:0]  top;
    logic              run;
    logic [15:0]       nip;
  } vm_result_t;

  logic [DataW-1:0] vm_stack [StackMax];
  logic [DataW-1:0] vm_regs [RegCountDef];
  logic [15:0]      vm_rets [CallMax];
  int               vm_sp;
  int               vm_rp;
  vm_result_t       result_q [$];
  int               fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();
  assign sp_o         = vm_sp;
  assign rp_o         = vm_rp;

  function automatic logic signed_lt(logic [63:0] a, logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [63:0] int_pow(logic [63:0] base, logic [63:0] ex);
    logic [63:0] acc;
    acc = 64'd1;
    if (ex[63]) return acc;
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // execute one instruction on the local machine state
  task automatic execute_instr(logic [95:0] d);
    logic [5:0]  act;
    logic [63:0] opnd, a, b, r, ma, mb, q;
    logic [3:0]  ri;
    logic [15:0] cur, nxt;
    logic        run;
    logic [2:0]  err;
    int          pops, pushes;
    vm_result_t  res;
    act = d[5:0]; opnd = d[69:6]; ri = d[73:70]; cur = d[89:74];
    nxt = cur + 16'd1; run = 1'b1; err = ErrNone;
    pops = 0; pushes = 0; a = 0; b = 0; r = 0;
    if (act == OpPush || act == OpLoad) pushes = 1;
    else if (act == OpPop || act == OpJmpIf || act == OpMov) pops = 1;
    else if (act == OpDup) begin pops = 1; pushes = 2; end
    else if (act == OpInc || act == OpAbs || act == OpNot) begin
      pops = 1; pushes = 1;
    end else if ((act >= OpEq && act <= OpGe) || (act >= OpAdd && act <= OpShr)) begin
      pops = 2; pushes = 1;
    end
    if (vm_sp < pops) err = ErrUnder;
    else if (vm_sp - pops + pushes > StackMax) err = ErrOver;
    else if (act == OpCall && vm_rp >= CallMax) err = ErrCallOvf;
    else if (pops == 2 && vm_stack[vm_sp-1] == 0 && (act == OpDiv || act == OpMod))
      err = (act == OpDiv) ? ErrDivZero : ErrModZero;
    if (err == ErrNone) begin
      if (pops == 2) begin a = vm_stack[vm_sp-2]; b = vm_stack[vm_sp-1]; end
      else if (pops == 1) a = vm_stack[vm_sp-1];
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      case (act)
        OpHalt:  run = 1'b0;
        OpPush:  r = opnd;
        OpDup:   r = a;
        OpJmp:   nxt = opnd[15:0];
        OpJmpIf: if (a != 0) nxt = opnd[15:0];
        OpEq:    r = 64'(a == b);
        OpNeq:   r = 64'(a != b);
        OpLt:    r = 64'(signed_lt(a, b));
        OpGt:    r = 64'(signed_lt(b, a));
        OpLe:    r = 64'(!signed_lt(b, a));
        OpGe:    r = 64'(!signed_lt(a, b));
        OpMov:   vm_regs[ri] = a;
        OpLoad:  r = vm_regs[ri];
        OpAdd:   r = a + b;
        OpSub:   r = a - b;
        OpMul:   r = a * b;
        OpDiv: begin
          q = ma / mb;
          r = (a[63] ^ b[63]) ? -q : q;
        end
        OpInc:   r = a + 64'd1;
        OpMod: begin
          q = ma % mb;
          r = a[63] ? -q : q;
        end
        OpPow:   r = int_pow(a, b);
        OpAbs:   r = ma;
        OpMin:   r = signed_lt(b, a) ? b : a;
        OpMax:   r = signed_lt(a, b) ? b : a;
        OpAnd:   r = a & b;
        OpOr:    r = a | b;
        OpXor:   r = a ^ b;
        OpNot:   r = ~a;
        OpShl:   r = a << b[5:0];
        OpShr:   r = $unsigned($signed(a) >>> b[5:0]);
        OpCall: begin
          vm_rets[vm_rp] = nxt;
          vm_rp++;
          nxt = opnd[15:0];
        end
        OpRet: begin
          if (vm_rp == 0) run = 1'b0;
          else begin
            vm_rp--;
            nxt = vm_rets[vm_rp];
          end
        end
        default: ;
      endcase
      vm_sp -= pops;
      if (pushes == 2) begin
        vm_stack[vm_sp] = a; vm_stack[vm_sp+1] = r;
      end else if (pushes == 1) vm_stack[vm_sp] = r;
      vm_sp += pushes;
    end else begin
      run = 1'b0;
      nxt = cur;
    end
    res.nip   = nxt;
    res.run   = run;
    res.top   = (vm_sp != 0) ? vm_stack[vm_sp-1] : 64'd0;
    res.depth = DepthW'(vm_sp);
    res.err   = err;
    result_q = {result_q, res};
  endtask

  // predict on accepted instructions, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    vm_result_t exp_r, got;
    if (!rst_ni) begin
      vm_sp = 0; vm_rp = 0; fails = 0;
      result_q.delete();
      for (int i = 0; i < RegCountDef; i++) vm_regs[i] = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[92:0];
        if (result_q.size() == 0) begin
          $error("result with no instruction pending");
          fails++;
        end else begin
          exp_r = result_q.pop_front();
          if (got.nip !== exp_r.nip) begin
            $error("next_ip exp %0h got %0h", exp_r.nip, got.nip); fails++;
          end
          if (got.run !== exp_r.run) begin
            $error("keep_running exp %0d got %0d", exp_r.run, got.run); fails++;
          end
          if (got.top !== exp_r.top) begin
            $error("top_value exp %0h got %0h", exp_r.top, got.top); fails++;
          end
          if (got.depth !== exp_r.depth) begin
            $error("stack_depth exp %0d got %0d", exp_r.depth, got.depth);
            fails++;
          end
          if (got.err !== exp_r.err) begin
            $error("error_code exp %0d got %0d", exp_r.err, got.err); fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) execute_instr(s_axis_tdata);
    end
  end

endmodule

>>> verif/stack_bytecode_executor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_executor_tb: testbench top of the stack bytecode executor
// Drives directed and random instruction streams under varying idle and
// stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_tb;
  import sbe_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          vm_sp;
  int          vm_rp;
  int          send_idle_pct;
  int          recv_stall_pct;

  stack_bytecode_executor dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  stack_bytecode_executor_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .sp_o(vm_sp), .rp_o(vm_rp)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #100ms;
    $display("FAIL stack_bytecode_executor");
    $finish;
  end

  // receiver with random stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // interesting operand values
  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return 64'd0;
      4: return 64'($urandom_range(70));
      5: return -64'($urandom_range(70));
      default: return rand64();
    endcase
  endfunction

  // send one instruction, optionally with random idle before it;
  // tvalid stays high afterwards until the next idle cycle or drain
  task automatic send_instr(logic [5:0] act, logic [63:0] opnd,
                            logic [3:0] ri, logic [15:0] ip);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, ip, ri, opnd, act};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // random instruction, biased toward keeping the stack shallow but busy
  task automatic send_random();
    logic [5:0]  act;
    logic [63:0] opnd;
    int          sel;
    sel = $urandom_range(99);
    if (sel < 4) act = 6'($urandom_range(33, 63));
    else if (vm_sp < 3 && sel < 60) act = OpPush;
    else if (vm_sp > 200 && sel < 60) act = OpPop;
    else if (sel < 22) act = OpPush;
    else act = 6'($urandom_range(0, 32));
    // div, mod and pow take their operand from the interesting values only
    if (act == OpDiv || act == OpMod || act == OpPow) opnd = pick_value();
    else opnd = ($urandom_range(3) == 0) ? rand64() : pick_value();
    if (act == OpPush && $urandom_range(4) == 0) opnd = 64'($urandom_range(9));
    send_instr(act, opnd, 4'($urandom()), 16'($urandom()));
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: underflow, halt, empty return, corners of arithmetic
    send_instr(OpPop, 0, 0, 16'hffff);
    send_instr(OpHalt, 0, 0, 16'hffff);
    send_instr(OpRet, 0, 0, 16'h0010);
    send_instr(OpPush, 64'h8000_0000_0000_0000, 0, 1);
    send_instr(OpPush, '1, 0, 2);
    send_instr(OpDiv, 0, 0, 3);
    send_instr(OpPush, 64'h8000_0000_0000_0000, 0, 4);
    send_instr(OpPush, '1, 0, 5);
    send_instr(OpMod, 0, 0, 6);
    send_instr(OpPush, 64'd0, 0, 7);
    send_instr(OpDiv, 0, 0, 8);
    send_instr(OpMod, 0, 0, 9);
    send_instr(OpPow, 0, 0, 10);
    send_instr(OpPush, 64'h8000_0000_0000_0000, 0, 11);
    send_instr(OpAbs, 0, 0, 12);
    send_instr(OpPush, 64'd127, 0, 13);
    send_instr(OpShr, 0, 0, 14);
    send_instr(OpMov, 0, 4'hf, 15);
    send_instr(OpLoad, 0, 4'hf, 16);
    send_instr(OpCall, 64'hffff_ffff_ffff_1234, 0, 16'hffff);
    send_instr(OpRet, 0, 0, 17);
    send_instr(OpJmpIf, 64'h7fff_ffff_ffff_abcd, 0, 18);
    send_instr(OpNot, 0, 0, 19);
    send_instr(OpJmp, 64'h5555, 0, 20);

    // fill the data stack to overflow, then empty it again
    while (vm_sp < StackDepthDef) send_instr(OpPush, rand64(), 0, 16'($urandom()));
    send_instr(OpDup, 0, 0, 21);
    send_instr(OpPush, 0, 0, 22);
    while (vm_sp > 0) send_instr(OpPop, 0, 0, 16'($urandom()));
    // fill the return stack to overflow, then unwind it
    while (vm_rp < CallDepthDef) send_instr(OpCall, rand64(), 0, 16'($urandom()));
    send_instr(OpCall, 0, 0, 23);
    while (vm_rp > 0) send_instr(OpRet, 0, 0, 16'($urandom()));
    wait_drained();

    // random phases with different idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 200; n++) send_random();
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("PASS stack_bytecode_executor");
    else $display("FAIL stack_bytecode_executor");
    $finish;
  end

endmodule
